@@ sv/mrve_pkg.sv @@
// Shared types and constants for the median range velocity estimator.
package mrve_pkg;
   localparam int RANGE_W = 16;
   localparam int TIME_W  = 32;
   localparam int SPEED_W = 32;
   localparam int WARMUP_SAMPLES = 5;
   // One second in microseconds, scaled by 256 for the Q24.8 result.
   localparam logic [28:0] US_PER_S_Q8 = 29'd256000000;

   typedef enum logic [1:0] {
      OUT_WARMUP     = 2'd0,
      OUT_HELD       = 2'd1,
      OUT_STATIONARY = 2'd2,
      OUT_MEDIAN     = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      CSR_DIST_DB  = 3'd0,
      CSR_VEL_DB   = 3'd1,
      CSR_MIN_GAP  = 3'd2,
      CSR_MAX_GAP  = 3'd3,
      CSR_ERR_LIM  = 3'd4
   } csr_index_type;

   // Divider request and reply.
   typedef struct packed {
      logic        start;
      logic        neg;
      logic [44:0] num;   // |dist| * 256e6, at most 45 bits
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [SPEED_W-1:0] slope;
   } div_rsp_type;
endpackage

@@ sv/median_range_velocity_estimator_unit.sv @@
// Top level: history memory, pair scan sequencer, serial divider and median sort.
// Each item scans the stored ages, divides once per valid pair and sorts the slopes
// before rsp_tvalid; while warming up the item goes straight to the output state.
// One item at a time: req_tready stays low until the response is taken.
// The divider works one quotient bit per cycle.
// Reset is synchronous and clears the history by its fill count, no clearing pass.
module median_range_velocity_estimator_unit #(
   parameter int HISTORY_DEPTH = 16,
   parameter int MAX_PAIRS     = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // range_cm [15:0], sample_time_us [47:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // speed_q8 [31:0], error_flag [32], outcome [34:33]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mrve_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam int PW = $clog2(MAX_PAIRS + 1);
   localparam int KW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_OLD, S_WAIT, S_CHECK, S_DIV, S_SORT, S_DONE, S_OUT
   } state_type;

   // Configuration registers.
   logic [15:0] dist_db_ff, vel_db_ff;
   logic [31:0] min_gap_ff, max_gap_ff;
   logic [7:0]  err_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_db_ff <= 16'd2;
         vel_db_ff  <= 16'd5;
         min_gap_ff <= 32'd1000;
         max_gap_ff <= 32'd50000;
         err_lim_ff <= 8'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIST_DB: dist_db_ff <= csr_wdata[15:0];
            CSR_VEL_DB:  vel_db_ff  <= csr_wdata[15:0];
            CSR_MIN_GAP: min_gap_ff <= csr_wdata;
            CSR_MAX_GAP: max_gap_ff <= csr_wdata;
            CSR_ERR_LIM: err_lim_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // History ring memory: entry head is the newest sample. The ring spans the
   // full address range so the head pointer wraps naturally.
   logic [47:0] hist_mem [2**AW];
   logic        mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [47:0] mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= hist_mem[mem_raddr];
   end

   state_type     state_ff;
   logic [AW-1:0] head_ff;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] age_ff;
   logic [15:0]   new_range_ff;
   logic [31:0]   new_time_ff;
   logic [PW-1:0] kept_ff, small_ff;
   logic signed [31:0] slopes_ff [MAX_PAIRS];
   logic [KW-1:0] sort_i_ff;
   logic [PW-1:0] sort_pass_ff;
   logic signed [31:0] held_ff;
   logic [7:0]    fail_ff;
   logic          err_ff;
   logic [31:0]   out_speed_ff;
   logic [1:0]    out_code_ff;
   logic          out_err_ff;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   mrve_divider u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   logic [FW-1:0] fill_next;
   logic [31:0]   gap;
   logic signed [16:0] range_delta;
   logic [15:0]   dist_mag;
   logic [AW-1:0] old_addr;
   logic          gap_ok;
   logic [PW-1:0] med_idx;
   logic signed [31:0] med;
   logic [32:0]   med_mag;

   assign fill_next = (fill_ff == FW'(HISTORY_DEPTH)) ? fill_ff : fill_ff + FW'(1);
   assign old_addr  = head_ff - AW'(age_ff);
   assign gap       = new_time_ff - mem_rdata_ff[47:16];
   assign range_delta = $signed({1'b0, new_range_ff}) - $signed({1'b0, mem_rdata_ff[15:0]});
   assign dist_mag  = range_delta[16] ? 16'(-range_delta) : range_delta[15:0];
   assign gap_ok    = (gap > min_gap_ff) && (gap < max_gap_ff);
   assign med_idx   = kept_ff >> 1;
   assign med       = slopes_ff[KW'(med_idx)];
   assign med_mag   = med[31] ? 33'(-{med[31], med}) : {1'b0, med};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = head_ff + AW'(1);
      mem_wdata = req_tdata;
      mem_raddr = old_addr;
      if (state_ff == S_IDLE && req_tvalid) mem_we = 1'b1;
      div_req.start = (state_ff == S_CHECK) && gap_ok;
      div_req.neg   = range_delta[16];
      div_req.num   = 45'(dist_mag) * 45'(US_PER_S_Q8);
      div_req.den   = gap;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'b0, out_code_ff, out_err_ff, out_speed_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         kept_ff  <= '0;
         held_ff  <= '0;
         fail_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               head_ff      <= head_ff + AW'(1);
               fill_ff      <= fill_next;
               new_range_ff <= req_tdata[15:0];
               new_time_ff  <= req_tdata[47:16];
               age_ff       <= FW'(2);
               kept_ff      <= '0;
               small_ff     <= '0;
               if (fill_next < FW'(WARMUP_SAMPLES)) begin
                  out_speed_ff <= '0;
                  out_code_ff  <= OUT_WARMUP;
                  out_err_ff   <= err_ff;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_RD_OLD;
               end
            end
            S_RD_OLD: begin
               if (age_ff >= fill_ff || kept_ff == PW'(MAX_PAIRS)) begin
                  sort_pass_ff <= '0;
                  sort_i_ff    <= '0;
                  state_ff     <= S_SORT;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: state_ff <= S_CHECK;
            S_CHECK: begin
               age_ff <= age_ff + FW'(2);
               if (gap_ok) begin
                  if (dist_mag <= dist_db_ff) small_ff <= small_ff + PW'(1);
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_RD_OLD;
               end
            end
            S_DIV: if (div_rsp.done) begin
               slopes_ff[KW'(kept_ff)] <= div_rsp.slope;
               kept_ff  <= kept_ff + PW'(1);
               state_ff <= S_RD_OLD;
            end
            S_SORT: begin
               // Bubble sort, one compare and swap per cycle.
               if (kept_ff > PW'(1) && PW'(sort_i_ff) < kept_ff - PW'(1)) begin
                  if (slopes_ff[sort_i_ff] > slopes_ff[sort_i_ff + KW'(1)]) begin
                     slopes_ff[sort_i_ff]          <= slopes_ff[sort_i_ff + KW'(1)];
                     slopes_ff[sort_i_ff + KW'(1)] <= slopes_ff[sort_i_ff];
                  end
                  sort_i_ff <= sort_i_ff + KW'(1);
               end else if (sort_pass_ff + PW'(1) < kept_ff) begin
                  sort_pass_ff <= sort_pass_ff + PW'(1);
                  sort_i_ff    <= '0;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_OUT;
               if (kept_ff == '0) begin
                  if (fail_ff != 8'hFF) begin
                     fail_ff    <= fail_ff + 8'd1;
                     err_ff     <= (fail_ff + 8'd1) > err_lim_ff;
                     out_err_ff <= (fail_ff + 8'd1) > err_lim_ff;
                  end else begin
                     err_ff     <= fail_ff > err_lim_ff;
                     out_err_ff <= fail_ff > err_lim_ff;
                  end
                  out_speed_ff <= held_ff;
                  out_code_ff  <= OUT_HELD;
               end else begin
                  fail_ff    <= '0;
                  err_ff     <= 1'b0;
                  out_err_ff <= 1'b0;
                  if (small_ff >= (kept_ff >> 1) + PW'(1)) begin
                     held_ff      <= '0;
                     out_speed_ff <= '0;
                     out_code_ff  <= OUT_STATIONARY;
                  end else if (med_mag <= {9'd0, vel_db_ff, 8'd0}) begin
                     held_ff      <= '0;
                     out_speed_ff <= '0;
                     out_code_ff  <= OUT_MEDIAN;
                  end else begin
                     held_ff      <= med;
                     out_speed_ff <= med;
                     out_code_ff  <= OUT_MEDIAN;
                  end
               end
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= PW'(MAX_PAIRS)) else $error("pair count over limit");
   a_small_le_kept: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> small_ff <= kept_ff) else $error("small count over pairs");
   a_err_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_code_ff == OUT_MEDIAN) |-> !out_err_ff)
      else $error("error flag with median result");
endmodule

@@ sv/mrve_divider.sv @@
// Restoring serial divider that returns a saturated signed Q24.8 slope.
module mrve_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mrve_pkg::div_req_type req,
   output mrve_pkg::div_rsp_type rsp
);
   import mrve_pkg::*;

   logic [44:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[44]};
      trial   = shifted[32:0] - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         neg_in  = req.neg;
         cnt_in  = 6'd45;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {2'b00, den_ff}) begin
            rem_in = trial;
            quo_in = {quo_ff[43:0], 1'b1};
         end else begin
            rem_in = shifted[32:0];
            quo_in = {quo_ff[43:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      rsp.done = done_ff;
      if (neg_ff) begin
         if (quo_ff > 45'h0_8000_0000) rsp.slope = 32'sh8000_0000;
         else rsp.slope = -$signed(quo_ff[31:0]);
      end else begin
         if (quo_ff > 45'h0_7FFF_FFFF) rsp.slope = 32'sh7FFF_FFFF;
         else rsp.slope = $signed(quo_ff[31:0]);
      end
   end
endmodule
